// File: rtl/assert_macros.svh
// Assertion macros for the RTL that carries concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on the rising clock edge, ignored while reset is high.
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Check that a condition implies another condition in the next cycle.
`define ASSERT_NEXT(label, cond, expect_next, msg) \
   label: assert property (@(posedge clock) disable iff (reset) \
      (cond) |=> (expect_next)) else $error(msg);

`endif

// File: rtl/ptlp_pkg.sv
// Types and constants of the proportional text layout parser.
`default_nettype none

package ptlp_pkg;

   // One glyph metric table entry.
   typedef struct packed {
      logic [1:0]  brush;
      logic [10:0] src_col;
      logic [10:0] width;
   } glyph_entry_type;

   // Stream parser phase, one-hot.
   typedef enum logic [5:0] {
      PH_XH   = 6'b000001,
      PH_XL   = 6'b000010,
      PH_YH   = 6'b000100,
      PH_YL   = 6'b001000,
      PH_TEXT = 6'b010000,
      PH_PAD  = 6'b100000
   } phase_type;

   // Result kinds.
   localparam logic [2:0] KIND_GLYPH  = 3'd0;
   localparam logic [2:0] KIND_SPACE  = 3'd1;
   localparam logic [2:0] KIND_END    = 3'd2;
   localparam logic [2:0] KIND_ABORT  = 3'd3;
   localparam logic [2:0] KIND_OTHER  = 3'd4;

   // Input item modes.
   localparam logic MODE_TABLE  = 1'b0;
   localparam logic MODE_STREAM = 1'b1;

   // Control bytes of the stream.
   localparam logic [7:0] BYTE_END    = 8'h00;
   localparam logic [7:0] BYTE_SPACE  = 8'h20;
   localparam logic [7:0] BYTE_TW_OFF = 8'hFD;
   localparam logic [7:0] BYTE_TW_ON  = 8'hFE;
   localparam logic [7:0] BYTE_NEW_XY = 8'hFF;

   // Configuration register indexes and reset values.
   localparam logic [1:0]  CSR_WRAP_LIMIT    = 2'd0;
   localparam logic [1:0]  CSR_LINE_STEP     = 2'd1;
   localparam logic [1:0]  CSR_SPACE_ADVANCE = 2'd2;
   localparam logic [15:0] WRAP_LIMIT_RESET    = 16'd319;
   localparam logic [7:0]  LINE_STEP_RESET     = 8'd15;
   localparam logic [7:0]  SPACE_ADVANCE_RESET = 8'd6;

endpackage

`default_nettype wire

// File: rtl/ptlp_glyph_ram.sv
// Glyph metric table: one write port, one registered read port.
`default_nettype none

module ptlp_glyph_ram
   import ptlp_pkg::*;
#(
   parameter int DEPTH  = 256,
   parameter int ADDR_W = 8
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  glyph_entry_type        wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output glyph_entry_type        rd_data
);

   glyph_entry_type mem_ff [DEPTH];
   glyph_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: rtl/proportional_text_layout_parser_top.sv
// Proportional text layout parser: top level with stream decoder and result register.
//
// Input channel (req_*, valid/ready): mode 0 writes one glyph metric table entry at
// req_glyph_slot, mode 1 delivers one byte of the encoded text stream. Table writes,
// coordinate and pad bytes, and typewriter and new-position bytes without abort give
// no result; every other stream byte gives one result item (rsp_*, valid/ready).
// Configuration (csr_we, csr_index, csr_wdata) writes wrap limit, line step and space
// advance; write only while no item is in flight.
// Path: the item lands in the stage register and its table read in the table's read
// register when it is accepted; the decode then loads the result register, raising
// rsp_valid. A result-channel stall holds the item in the stage register before that.
// Throughput: one item per cycle while the result channel does not stall, set by the
// decode of the stage register and the one read port of the table.
// Reset: req_ready is low, parser returns to awaiting the x high byte, cursor and modes
// clear, the configuration returns to 319 / 15 / 6. Table contents are not cleared;
// entries must be written before a glyph that uses them is sent.
// Stall: when rsp_ready is low the result register holds; items that give no result
// keep flowing, the first item that needs one waits in the stage register and
// req_ready drops until the result is taken.
`default_nettype none

`include "assert_macros.svh"

module proportional_text_layout_parser_top
   import ptlp_pkg::*;
#(
   parameter int TABLE_DEPTH = 256,
   parameter int FIRST_CODE  = 33
) (
   input  wire logic              clock,
   input  wire logic              reset,
   // input channel
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic              req_mode,
   input  wire logic [7:0]        req_glyph_slot,
   input  wire logic [1:0]        req_entry_brush,
   input  wire logic [10:0]       req_entry_src_col,
   input  wire logic [10:0]       req_entry_width,
   input  wire logic [7:0]        req_stream_byte,
   input  wire logic              req_abort_pressed,
   // result channel
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic [2:0]             rsp_kind,
   output logic [7:0]             rsp_glyph_code,
   output logic signed [15:0]     rsp_draw_x,
   output logic signed [15:0]     rsp_draw_y,
   output logic [1:0]             rsp_glyph_brush,
   output logic [10:0]            rsp_glyph_src_col,
   output logic [10:0]            rsp_glyph_width,
   output logic                   rsp_sound_pulse,
   output logic                   rsp_typing_pause,
   // configuration
   input  wire logic              csr_we,
   input  wire logic [1:0]        csr_index,
   input  wire logic [15:0]       csr_wdata
);

   localparam int ADDR_W = $clog2(TABLE_DEPTH);
   localparam logic [8:0] DEPTH_9 = 9'(TABLE_DEPTH);
   localparam logic [8:0] FIRST_9 = 9'(FIRST_CODE);
   localparam logic [7:0] FIRST_8 = 8'(FIRST_CODE);

   // configuration
   logic [15:0] wrap_limit_ff;
   logic [7:0]  line_step_ff;
   logic [7:0]  space_advance_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wrap_limit_ff    <= WRAP_LIMIT_RESET;
         line_step_ff     <= LINE_STEP_RESET;
         space_advance_ff <= SPACE_ADVANCE_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_WRAP_LIMIT:    wrap_limit_ff    <= csr_wdata;
            CSR_LINE_STEP:     line_step_ff     <= csr_wdata[7:0];
            CSR_SPACE_ADVANCE: space_advance_ff <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   // input side: table write and table read address
   logic            req_fire;
   logic            tbl_wr_en;
   logic [8:0]      rd_idx;
   logic [ADDR_W-1:0] rd_addr;
   glyph_entry_type wr_entry;
   glyph_entry_type rd_entry;

   assign req_fire  = req_valid && req_ready;
   assign tbl_wr_en = req_fire && (req_mode == MODE_TABLE) && ({1'b0, req_glyph_slot} < DEPTH_9);
   assign rd_idx    = {1'b0, req_stream_byte} - FIRST_9;
   // out-of-table glyphs use entry zero
   assign rd_addr   = (rd_idx < DEPTH_9) ? rd_idx[ADDR_W-1:0] : '0;
   assign wr_entry  = '{brush: req_entry_brush, src_col: req_entry_src_col,
                        width: req_entry_width};

   ptlp_glyph_ram #(
      .DEPTH  (TABLE_DEPTH),
      .ADDR_W (ADDR_W)
   ) u_glyph_ram (
      .clock   (clock),
      .wr_en   (tbl_wr_en),
      .wr_addr (req_glyph_slot[ADDR_W-1:0]),
      .wr_data (wr_entry),
      .rd_en   (req_fire && (req_mode == MODE_STREAM)),
      .rd_addr (rd_addr),
      .rd_data (rd_entry)
   );

   // stage register
   logic       s1_valid_ff;
   logic       s1_mode_ff;
   logic [7:0] s1_byte_ff;
   logic       s1_abort_ff;
   logic       s1_adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_mode_ff  <= req_mode;
         s1_byte_ff  <= req_stream_byte;
         s1_abort_ff <= req_abort_pressed;
      end
   end

   // parser state
   phase_type   phase_ff, phase_in;
   logic [7:0]  coord_hi_ff, coord_hi_in;
   logic [15:0] cursor_x_ff, cursor_x_in;
   logic [15:0] cursor_y_ff, cursor_y_in;
   logic        typewriter_ff, typewriter_in;
   logic        sound_ff, sound_in;
   logic        parity_ff, parity_in;

   // decode results
   logic            has_rsp;
   logic [2:0]      kind_c;
   logic [7:0]      code_c;
   logic [15:0]     pos_x_c;
   logic [15:0]     pos_y_c;
   glyph_entry_type ent_c;
   logic            snd_c;
   logic            pause_c;
   logic            wraps;
   logic [15:0]     glyph_x;
   logic            is_end;

   assign wraps = ($signed({{2{cursor_x_ff[15]}}, cursor_x_ff})
                   + $signed({7'd0, rd_entry.width}))
                  > $signed({2'd0, wrap_limit_ff});
   assign glyph_x = wraps ? 16'd0 : cursor_x_ff;

   always_comb begin
      phase_in      = phase_ff;
      coord_hi_in   = coord_hi_ff;
      cursor_x_in   = cursor_x_ff;
      cursor_y_in   = cursor_y_ff;
      typewriter_in = typewriter_ff;
      sound_in      = sound_ff;
      parity_in     = parity_ff;
      has_rsp       = 1'b0;
      is_end        = 1'b0;
      kind_c        = KIND_OTHER;
      code_c        = s1_byte_ff;
      pos_x_c       = cursor_x_ff;
      pos_y_c       = cursor_y_ff;
      ent_c         = '0;
      snd_c         = 1'b0;
      pause_c       = 1'b0;
      if (s1_mode_ff == MODE_STREAM) begin
         if (phase_ff != PH_TEXT) begin
            parity_in = !parity_ff;
            case (phase_ff)
               PH_XL: begin
                  cursor_x_in = {coord_hi_ff, s1_byte_ff};
                  phase_in    = PH_YH;
               end
               PH_YH: begin
                  coord_hi_in = s1_byte_ff;
                  phase_in    = PH_YL;
               end
               PH_YL: begin
                  cursor_y_in = {coord_hi_ff, s1_byte_ff};
                  phase_in    = PH_TEXT;
               end
               PH_PAD: begin
                  phase_in = PH_XH;
               end
               default: begin
                  coord_hi_in = s1_byte_ff;
                  phase_in    = PH_XL;
               end
            endcase
         end else if (s1_byte_ff == BYTE_END || s1_abort_ff) begin
            // zero ends the string even when abort is set
            has_rsp       = 1'b1;
            is_end        = 1'b1;
            kind_c        = (s1_byte_ff == BYTE_END) ? KIND_END : KIND_ABORT;
            phase_in      = PH_XH;
            typewriter_in = 1'b0;
            sound_in      = 1'b0;
            parity_in     = 1'b0;
         end else begin
            parity_in = !parity_ff;
            if (s1_byte_ff == BYTE_TW_ON) begin
               typewriter_in = 1'b1;
            end else if (s1_byte_ff == BYTE_TW_OFF) begin
               typewriter_in = 1'b0;
            end else if (s1_byte_ff == BYTE_NEW_XY) begin
               phase_in = parity_in ? PH_PAD : PH_XH;
            end else begin
               has_rsp  = 1'b1;
               sound_in = !sound_ff;
               snd_c    = sound_ff;
               pause_c  = typewriter_ff;
               if (s1_byte_ff == BYTE_SPACE) begin
                  kind_c      = KIND_SPACE;
                  cursor_x_in = cursor_x_ff + {8'd0, space_advance_ff};
               end else if (s1_byte_ff >= FIRST_8) begin
                  kind_c      = KIND_GLYPH;
                  ent_c       = rd_entry;
                  pos_x_c     = glyph_x;
                  if (wraps) begin
                     pos_y_c     = cursor_y_ff + {8'd0, line_step_ff};
                     cursor_y_in = pos_y_c;
                  end
                  cursor_x_in = glyph_x + {5'd0, rd_entry.width};
               end else begin
                  kind_c = KIND_OTHER;
               end
            end
         end
      end
   end

   logic out_free;
   assign out_free  = !rsp_valid || rsp_ready;
   assign s1_adv    = s1_valid_ff && (!has_rsp || out_free);
   assign req_ready = !reset && (!s1_valid_ff || s1_adv);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_XH;
         coord_hi_ff   <= '0;
         cursor_x_ff   <= '0;
         cursor_y_ff   <= '0;
         typewriter_ff <= 1'b0;
         sound_ff      <= 1'b0;
         parity_ff     <= 1'b0;
      end else if (s1_adv) begin
         phase_ff      <= phase_in;
         coord_hi_ff   <= coord_hi_in;
         cursor_x_ff   <= cursor_x_in;
         cursor_y_ff   <= cursor_y_in;
         typewriter_ff <= typewriter_in;
         sound_ff      <= sound_in;
         parity_ff     <= parity_in;
      end
   end

   // result register
   logic rsp_valid_ff;
   logic rsp_load;
   assign rsp_load = s1_adv && has_rsp;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_kind           <= kind_c;
         rsp_glyph_code     <= (kind_c == KIND_END) ? 8'd0 : code_c;
         rsp_draw_x         <= $signed(pos_x_c);
         rsp_draw_y         <= $signed(pos_y_c);
         rsp_glyph_brush    <= ent_c.brush;
         rsp_glyph_src_col  <= ent_c.src_col;
         rsp_glyph_width    <= ent_c.width;
         rsp_sound_pulse    <= snd_c;
         rsp_typing_pause   <= pause_c;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // checks
   logic stall_hold;
   logic rsp_non_glyph;
   logic rsp_metrics_zero;
   logic end_taken;
   logic state_idle;

   assign stall_hold       = s1_valid_ff && has_rsp && rsp_valid && !rsp_ready;
   assign rsp_non_glyph    = rsp_valid && (rsp_kind != KIND_GLYPH);
   assign rsp_metrics_zero = (rsp_glyph_width == 11'd0) && (rsp_glyph_brush == 2'd0)
                             && (rsp_glyph_src_col == 11'd0);
   assign end_taken        = s1_adv && is_end;
   assign state_idle       = (phase_ff == PH_XH) && !typewriter_ff && !sound_ff && !parity_ff;

   `ASSERT_NEXT(a_stall_holds_item, stall_hold, s1_valid_ff && rsp_valid, "item lost in stall")
   `ASSERT_CLK(a_metrics_only_glyph, rsp_non_glyph |-> rsp_metrics_zero, "metrics on non-glyph")
   `ASSERT_NEXT(a_end_clears_state, end_taken, state_idle, "string end left parser state")

endmodule

`default_nettype wire
